@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the IMU scaler.
// Each check samples on the rising edge of i_clk.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that is disabled while reset is asserted.
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that is also evaluated during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(label, prop, msg)
`define ASSERT_CLK(label, prop, msg)

`endif

`endif

@@ rtl/imuars_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imuars_pkg: IMU auto-range scaler package
// Widths, register map, reset values and small per-sample helpers.
// ----------------------------------------------------------------------------
package imuars_pkg;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned BASE_W  = 25;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned MULT_W  = 13;
    localparam int unsigned OUT_W   = 29;
    localparam int unsigned MAG_W   = 17;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [CODE_W-1:0] RANGE_CODE_MAX = 2'd3;
    localparam logic [CODE_W-1:0] RANGE_CODE_MIN = 2'd0;
    localparam logic [3:0]        SHIFT_TOP      = 4'd15;

    localparam logic [BASE_W-1:0] ACC_BASE_RST = 25'd19613300;
    localparam logic [BASE_W-1:0] GYR_BASE_RST = 25'd4363323;
    localparam logic [THR_W-1:0]  UP_THR_RST   = 16'd29491;
    localparam logic [THR_W-1:0]  DN_THR_RST   = 16'd13108;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_ACC_BASE = 2'd0,
        REG_GYR_BASE = 2'd1,
        REG_UP_THR   = 2'd2,
        REG_DN_THR   = 2'd3
    } t_reg_idx;

    typedef logic [RAW_W-1:0] t_raw;

    // Swap the bytes of a big-endian sample.
    function automatic logic signed [RAW_W-1:0] swap_bytes(input t_raw raw);
        return $signed({raw[7:0], raw[15:8]});
    endfunction

    // Magnitude of a signed sample; the most negative value does not wrap.
    function automatic logic [MAG_W-1:0] sample_mag(input logic signed [RAW_W-1:0] v);
        logic signed [MAG_W-1:0] ext;
        ext = MAG_W'(v);
        return v[RAW_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
    endfunction

    // Signed sample times unsigned multiplier, kept to the output width.
    function automatic logic [OUT_W-1:0] scale_sample(input logic signed [RAW_W-1:0] v,
                                                     input logic [MULT_W-1:0] mult);
        logic signed [OUT_W:0] prod;
        prod = v * $signed({1'b0, mult});
        return prod[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/imu_autorange_scaler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_autorange_scaler: IMU frame scaling with range hysteresis
// Swaps and scales six raw samples per frame and steps the accelerometer
// and gyro range codes up or down from the per-sensor peak magnitude.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Carries
//  in        input      i_in_valid / o_in_ready     six raw samples
//  out       output     o_out_valid / i_out_ready   six scaled values, range codes
//  cfg       input      psel/penable/pwrite/pready  four registers, 32-bit data
//
//  One frame per cycle while the output is not stalled; an accepted request
//  passes through the input register, then the result register.
//  Range state advances when a frame moves into the result register.
//  A stalled output keeps its result; the input register still takes one more
//  request, after which o_in_ready drops until the output drains.
//  Reset clears the control flags and range codes and loads the configuration
//  registers with their reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_autorange_scaler (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input frame channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [15:0]         i_accel_x_raw,
    input  wire logic [15:0]         i_accel_y_raw,
    input  wire logic [15:0]         i_accel_z_raw,
    input  wire logic [15:0]         i_gyro_x_raw,
    input  wire logic [15:0]         i_gyro_y_raw,
    input  wire logic [15:0]         i_gyro_z_raw,
    // Result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [28:0]       o_accel_x_scaled,
    output logic signed [28:0]       o_accel_y_scaled,
    output logic signed [28:0]       o_accel_z_scaled,
    output logic signed [28:0]       o_gyro_x_scaled,
    output logic signed [28:0]       o_gyro_y_scaled,
    output logic signed [28:0]       o_gyro_z_scaled,
    output logic                     o_accel_range_write,
    output logic [1:0]               o_accel_range_code,
    output logic                     o_gyro_range_write,
    output logic [1:0]               o_gyro_range_code,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned NUM_AX = 6;

    // Configuration registers
    logic [imuars_pkg::BASE_W-1:0] r_acc_base;
    logic [imuars_pkg::BASE_W-1:0] r_gyr_base;
    logic [imuars_pkg::THR_W-1:0]  r_up_thr;
    logic [imuars_pkg::THR_W-1:0]  r_dn_thr;

    // Range state
    logic [imuars_pkg::CODE_W-1:0] r_acc_sel;
    logic [imuars_pkg::CODE_W-1:0] r_gyr_sel;
    logic [imuars_pkg::CODE_W-1:0] n_acc_sel;
    logic [imuars_pkg::CODE_W-1:0] n_gyr_sel;

    // Input register
    logic               r_s1_valid;
    imuars_pkg::t_raw   r_s1_raw [NUM_AX];

    // Result register
    logic                          r_out_valid;
    logic [imuars_pkg::OUT_W-1:0]  r_out_scaled [NUM_AX];
    logic [imuars_pkg::OUT_W-1:0]  n_out_scaled [NUM_AX];
    logic                          r_out_acc_wr;
    logic                          r_out_gyr_wr;
    logic [imuars_pkg::CODE_W-1:0] r_out_acc_code;
    logic [imuars_pkg::CODE_W-1:0] r_out_gyr_code;

    logic w_out_free;
    logic w_s1_move;
    logic w_in_take;
    logic w_cfg_wr;
    imuars_pkg::t_reg_idx w_reg_idx;

    logic [imuars_pkg::MULT_W-1:0] w_acc_mult;
    logic [imuars_pkg::MULT_W-1:0] w_gyr_mult;
    logic [imuars_pkg::MAG_W-1:0]  w_mag [NUM_AX];
    logic [imuars_pkg::MAG_W-1:0]  w_acc_peak;
    logic [imuars_pkg::MAG_W-1:0]  w_gyr_peak;

    // Handshake control
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    // Configuration port decode
    assign pready    = 1'b1;
    assign w_reg_idx = imuars_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            imuars_pkg::REG_ACC_BASE: prdata = 32'(r_acc_base);
            imuars_pkg::REG_GYR_BASE: prdata = 32'(r_gyr_base);
            imuars_pkg::REG_UP_THR:   prdata = 32'(r_up_thr);
            imuars_pkg::REG_DN_THR:   prdata = 32'(r_dn_thr);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_base <= imuars_pkg::ACC_BASE_RST;
            r_gyr_base <= imuars_pkg::GYR_BASE_RST;
            r_up_thr   <= imuars_pkg::UP_THR_RST;
            r_dn_thr   <= imuars_pkg::DN_THR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                imuars_pkg::REG_ACC_BASE: r_acc_base <= pwdata[imuars_pkg::BASE_W-1:0];
                imuars_pkg::REG_GYR_BASE: r_gyr_base <= pwdata[imuars_pkg::BASE_W-1:0];
                imuars_pkg::REG_UP_THR:   r_up_thr   <= pwdata[imuars_pkg::THR_W-1:0];
                imuars_pkg::REG_DN_THR:   r_dn_thr   <= pwdata[imuars_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Multipliers: base scale shifted right by fifteen minus the range code.
    always_comb begin
        logic [imuars_pkg::BASE_W-1:0] acc_sh;
        logic [imuars_pkg::BASE_W-1:0] gyr_sh;
        acc_sh     = r_acc_base >> (imuars_pkg::SHIFT_TOP - {2'b00, r_acc_sel});
        gyr_sh     = r_gyr_base >> (imuars_pkg::SHIFT_TOP - {2'b00, r_gyr_sel});
        w_acc_mult = acc_sh[imuars_pkg::MULT_W-1:0];
        w_gyr_mult = gyr_sh[imuars_pkg::MULT_W-1:0];
    end

    // Byte swap, scale and magnitude per axis.
    always_comb begin
        logic signed [imuars_pkg::RAW_W-1:0] v;
        for (int i = 0; i < NUM_AX; i++) begin
            v               = imuars_pkg::swap_bytes(r_s1_raw[i]);
            w_mag[i]        = imuars_pkg::sample_mag(v);
            n_out_scaled[i] = imuars_pkg::scale_sample(v, (i < 3) ? w_acc_mult : w_gyr_mult);
        end
    end

    // Peak magnitude per sensor.
    always_comb begin
        logic [imuars_pkg::MAG_W-1:0] a01;
        logic [imuars_pkg::MAG_W-1:0] g01;
        a01        = (w_mag[1] > w_mag[0]) ? w_mag[1] : w_mag[0];
        w_acc_peak = (w_mag[2] > a01) ? w_mag[2] : a01;
        g01        = (w_mag[4] > w_mag[3]) ? w_mag[4] : w_mag[3];
        w_gyr_peak = (w_mag[5] > g01) ? w_mag[5] : g01;
    end

    // Range hysteresis; a step up wins over a step down.
    always_comb begin
        logic [imuars_pkg::MAG_W-1:0] up_thr;
        logic [imuars_pkg::MAG_W-1:0] dn_thr;
        up_thr = imuars_pkg::MAG_W'(r_up_thr);
        dn_thr = imuars_pkg::MAG_W'(r_dn_thr);
        priority if (r_acc_sel != imuars_pkg::RANGE_CODE_MAX && w_acc_peak > up_thr) begin
            n_acc_sel = r_acc_sel + 2'd1;
        end else if (r_acc_sel != imuars_pkg::RANGE_CODE_MIN && w_acc_peak < dn_thr) begin
            n_acc_sel = r_acc_sel - 2'd1;
        end else begin
            n_acc_sel = r_acc_sel;
        end
        priority if (r_gyr_sel != imuars_pkg::RANGE_CODE_MAX && w_gyr_peak > up_thr) begin
            n_gyr_sel = r_gyr_sel + 2'd1;
        end else if (r_gyr_sel != imuars_pkg::RANGE_CODE_MIN && w_gyr_peak < dn_thr) begin
            n_gyr_sel = r_gyr_sel - 2'd1;
        end else begin
            n_gyr_sel = r_gyr_sel;
        end
    end

    // Input register control and range state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_sel   <= imuars_pkg::RANGE_CODE_MIN;
            r_gyr_sel   <= imuars_pkg::RANGE_CODE_MIN;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
                r_acc_sel   <= n_acc_sel;
                r_gyr_sel   <= n_gyr_sel;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_raw[0] <= i_accel_x_raw;
            r_s1_raw[1] <= i_accel_y_raw;
            r_s1_raw[2] <= i_accel_z_raw;
            r_s1_raw[3] <= i_gyro_x_raw;
            r_s1_raw[4] <= i_gyro_y_raw;
            r_s1_raw[5] <= i_gyro_z_raw;
        end
        if (w_s1_move) begin
            r_out_scaled   <= n_out_scaled;
            r_out_acc_wr   <= (n_acc_sel != r_acc_sel);
            r_out_gyr_wr   <= (n_gyr_sel != r_gyr_sel);
            r_out_acc_code <= n_acc_sel;
            r_out_gyr_code <= n_gyr_sel;
        end
    end

    // Outputs
    assign o_out_valid         = r_out_valid;
    assign o_accel_x_scaled    = $signed(r_out_scaled[0]);
    assign o_accel_y_scaled    = $signed(r_out_scaled[1]);
    assign o_accel_z_scaled    = $signed(r_out_scaled[2]);
    assign o_gyro_x_scaled     = $signed(r_out_scaled[3]);
    assign o_gyro_y_scaled     = $signed(r_out_scaled[4]);
    assign o_gyro_z_scaled     = $signed(r_out_scaled[5]);
    assign o_accel_range_write = r_out_acc_wr;
    assign o_accel_range_code  = r_out_acc_code;
    assign o_gyro_range_write  = r_out_gyr_wr;
    assign o_gyro_range_code   = r_out_gyr_code;

    // Checks
    `ASSERT_CLK_RST(a_acc_one_step, (r_acc_sel != $past(r_acc_sel)) |-> ((r_acc_sel == $past(r_acc_sel) + 2'd1) || (r_acc_sel == $past(r_acc_sel) - 2'd1)), "accel range code jumped by more than one step")
    `ASSERT_CLK_RST(a_out_code_state, r_out_valid |-> ((r_out_acc_code == r_acc_sel) && (r_out_gyr_code == r_gyr_sel)), "reported range code differs from range state")
    `ASSERT_CLK_RST(a_ready_when_empty, !r_out_valid |-> o_in_ready, "input stalled while the output register is empty")
    `ASSERT_CLK(a_reset_clears, !i_rst_n |=> (!r_s1_valid && !r_out_valid), "valid flags not cleared by reset")

endmodule
`default_nettype wire

@@ tb/tb_imu_autorange_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_autorange_scaler: self-checking bench for the IMU auto-range scaler
// Drives frames of six big-endian samples, predicts the scaled values and the
// range-code hysteresis of both sensors, and checks every result in order.
// Registers are set over APB between phases and read back after each write.
// ----------------------------------------------------------------------------
module tb_imu_autorange_scaler;
    import imuars_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 100;
    localparam int FRAMES_PER_PHASE = 376;

    typedef logic [5:0][RAW_W-1:0] t_frame;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] acc_scaled;
        logic                  acc_wr;
        logic [CODE_W-1:0]     acc_code;
        logic [2:0][OUT_W-1:0] gyr_scaled;
        logic                  gyr_wr;
        logic [CODE_W-1:0]     gyr_code;
    } t_range_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [RAW_W-1:0]      i_accel_x_raw = '0;
    logic [RAW_W-1:0]      i_accel_y_raw = '0;
    logic [RAW_W-1:0]      i_accel_z_raw = '0;
    logic [RAW_W-1:0]      i_gyro_x_raw  = '0;
    logic [RAW_W-1:0]      i_gyro_y_raw  = '0;
    logic [RAW_W-1:0]      i_gyro_z_raw  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [28:0]    o_accel_x_scaled;
    logic signed [28:0]    o_accel_y_scaled;
    logic signed [28:0]    o_accel_z_scaled;
    logic signed [28:0]    o_gyro_x_scaled;
    logic signed [28:0]    o_gyro_y_scaled;
    logic signed [28:0]    o_gyro_z_scaled;
    logic                  o_accel_range_write;
    logic [1:0]            o_accel_range_code;
    logic                  o_gyro_range_write;
    logic [1:0]            o_gyro_range_code;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Register shadows and range codes as the block should hold them.
    logic [BASE_W-1:0]     acc_base = ACC_BASE_RST;
    logic [BASE_W-1:0]     gyr_base = GYR_BASE_RST;
    logic [THR_W-1:0]      up_thr   = UP_THR_RST;
    logic [THR_W-1:0]      dn_thr   = DN_THR_RST;
    logic [CODE_W-1:0]     acc_range = RANGE_CODE_MIN;
    logic [CODE_W-1:0]     gyr_range = RANGE_CODE_MIN;

    t_range_result         pending_results[$];
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    mismatch_count = 0;
    int                    result_count   = 0;
    int                    stall_cycles   = 0;
    string                 axis_name[3] = '{"x", "y", "z"};

    imu_autorange_scaler u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_accel_x_raw       (i_accel_x_raw),
        .i_accel_y_raw       (i_accel_y_raw),
        .i_accel_z_raw       (i_accel_z_raw),
        .i_gyro_x_raw        (i_gyro_x_raw),
        .i_gyro_y_raw        (i_gyro_y_raw),
        .i_gyro_z_raw        (i_gyro_z_raw),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_accel_x_scaled    (o_accel_x_scaled),
        .o_accel_y_scaled    (o_accel_y_scaled),
        .o_accel_z_scaled    (o_accel_z_scaled),
        .o_gyro_x_scaled     (o_gyro_x_scaled),
        .o_gyro_y_scaled     (o_gyro_y_scaled),
        .o_gyro_z_scaled     (o_gyro_z_scaled),
        .o_accel_range_write (o_accel_range_write),
        .o_accel_range_code  (o_accel_range_code),
        .o_gyro_range_write  (o_gyro_range_write),
        .o_gyro_range_code   (o_gyro_range_code),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Big-endian byte order of a signed sample value, as the sensor sends it.
    function automatic logic [RAW_W-1:0] be16(input int value);
        logic [RAW_W-1:0] v;
        v = RAW_W'(value);
        return {v[7:0], v[15:8]};
    endfunction

    // Raw sample with the given magnitude and a random sign; 32768 is negative only.
    function automatic logic [RAW_W-1:0] raw_from_mag(input int unsigned mag);
        int value;
        value = int'(mag);
        if (mag >= 32768 || $urandom_range(0, 1) == 1) begin
            value = -value;
        end
        return be16(value);
    endfunction

    // One sensor: scale three samples with the current code, then step the code
    // from the peak magnitude. A step up wins over a step down.
    function automatic void step_sensor(input logic [2:0][RAW_W-1:0] raw,
                                        input logic [BASE_W-1:0] base,
                                        inout logic [CODE_W-1:0] code,
                                        output logic [2:0][OUT_W-1:0] scaled,
                                        output logic wr);
        logic [MULT_W-1:0] mult;
        logic [MAG_W-1:0]  peak;
        logic [MAG_W-1:0]  mag;
        logic [RAW_W-1:0]  swapped;
        logic [CODE_W-1:0] prev;
        int                sample;
        prev = code;
        mult = MULT_W'(base >> (SHIFT_TOP - code));
        peak = '0;
        for (int i = 0; i < 3; i++) begin
            swapped   = {raw[i][7:0], raw[i][15:8]};
            sample    = int'($signed(swapped));
            mag       = MAG_W'(sample < 0 ? -sample : sample);
            scaled[i] = OUT_W'(sample * int'(mult));
            if (mag > peak) begin
                peak = mag;
            end
        end
        if (code != RANGE_CODE_MAX && peak > MAG_W'(up_thr)) begin
            code = code + 1'b1;
        end else if (code != RANGE_CODE_MIN && peak < MAG_W'(dn_thr)) begin
            code = code - 1'b1;
        end
        wr = (code != prev);
    endfunction

    // Register write followed by a read-back of the same register.
    task automatic cfg_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // The write has landed; go straight into the setup of a read.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            report_mismatch($sformatf("register %s read back 0x%0h, wrote 0x%0h",
                                      idx.name(), prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ACC_BASE: acc_base = value[BASE_W-1:0];
            REG_GYR_BASE: gyr_base = value[BASE_W-1:0];
            REG_UP_THR:   up_thr   = value[THR_W-1:0];
            REG_DN_THR:   dn_thr   = value[THR_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic cfg_all(input int unsigned acc, input int unsigned gyr,
                           input int unsigned up, input int unsigned dn);
        cfg_write(REG_ACC_BASE, DATA_W'(acc));
        cfg_write(REG_GYR_BASE, DATA_W'(gyr));
        cfg_write(REG_UP_THR, DATA_W'(up));
        cfg_write(REG_DN_THR, DATA_W'(dn));
    endtask

    // Random registers; inverted puts the down threshold above the up threshold.
    task automatic random_config(input bit inverted);
        int unsigned acc;
        int unsigned gyr;
        int unsigned hi;
        int unsigned lo;
        acc = ($urandom_range(0, 3) == 0) ? 33554431 : $urandom_range(0, 33554431);
        gyr = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 33554431);
        hi  = $urandom_range(12000, 32768);
        lo  = $urandom_range(1, hi);
        if (inverted) begin
            cfg_all(acc, gyr, lo, hi);
        end else begin
            cfg_all(acc, gyr, hi, lo);
        end
    endtask

    // Sends one request and records the result it should produce.
    task automatic send_frame(input t_frame f);
        t_range_result want;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        {i_gyro_z_raw, i_gyro_y_raw, i_gyro_x_raw,
         i_accel_z_raw, i_accel_y_raw, i_accel_x_raw} <= f;
        do @(posedge i_clk); while (!o_in_ready);
        step_sensor(f[2:0], acc_base, acc_range, want.acc_scaled, want.acc_wr);
        want.acc_code = acc_range;
        step_sensor(f[5:3], gyr_base, gyr_range, want.gyr_scaled, want.gyr_wr);
        want.gyr_code = gyr_range;
        pending_results.push_back(want);
    endtask

    task automatic send_values(input int ax, input int ay, input int az,
                               input int gx, input int gy, input int gz);
        send_frame({be16(gz), be16(gy), be16(gx), be16(az), be16(ay), be16(ax)});
    endtask

    // Stop sending and let every pending result drain.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random frame: each sensor is quiet, loud, in between, or fully random,
    // so the range codes keep moving in both directions.
    function automatic t_frame random_frame();
        t_frame      f;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        for (int s = 0; s < 2; s++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                lo = 0;
                hi = dn_thr;
            end else if (pick < 6) begin
                lo = up_thr;
                hi = 32768;
            end else begin
                lo = (up_thr < dn_thr) ? up_thr : dn_thr;
                hi = (up_thr < dn_thr) ? dn_thr : up_thr;
            end
            if (hi > 32768) begin
                hi = 32768;
            end
            for (int a = 0; a < 3; a++) begin
                if (pick >= 8) begin
                    f[s*3 + a] = RAW_W'($urandom);
                end else begin
                    f[s*3 + a] = raw_from_mag($urandom_range(lo, hi));
                end
            end
        end
        return f;
    endfunction

    task automatic run_frames(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            send_frame(random_frame());
        end
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Walks both range codes up to the top and back down with the reset registers.
    task automatic test_range_stepping();
        send_values(0, 0, 0, 0, 0, 0);
        send_values(-32768, 5, -5, -32768, 0, 7);
        send_values(32767, 0, 0, 0, 32767, 0);
        send_values(0, -29492, 0, 0, 0, 29492);
        // Both codes at the top: loud frame holds without a write.
        send_values(32767, 32767, -32768, -32768, 32767, 32767);
        send_values(29491, 0, 0, -29491, 0, 0);
        send_values(1, -1, 0, 256, -256, 255);
        send_values(13108, 0, 0, 0, -13108, 0);
        send_values(13107, 0, 0, 0, 0, -13107);
        send_values(100, 200, 300, -100, -200, -300);
        send_values(0, 0, 0, 0, 0, 0);
        send_values(30000, 0, 0, 0, 0, 0);
        send_values(20000, -20000, 1, 20000, 0, 0);
        send_values(0, 0, 0, 32000, 0, 0);
        wait_idle();
    endtask

    // Register extremes, including both thresholds firing at once.
    task automatic test_register_extremes();
        cfg_all(33554431, 33554431, 0, 32768);
        send_values(1, 0, 0, 0, 0, -1);
        send_values(-32768, 32767, 0, 32767, -32768, 0);
        send_values(32767, -1, 1, -1, 1, 32767);
        send_values(-32768, -32768, -32768, -32768, -32768, -32768);
        send_values(0, 0, 0, 0, 0, 0);
        send_values(0, 0, 0, 0, 0, 0);
        wait_idle();
        // Zero scale and thresholds that can never fire.
        cfg_all(0, 0, 32768, 0);
        send_values(-32768, -32768, -32768, -32768, -32768, -32768);
        send_values(0, 0, 0, 0, 0, 0);
        wait_idle();
    endtask

    task automatic test_steady_stream();
        cfg_all(ACC_BASE_RST, GYR_BASE_RST, UP_THR_RST, DN_THR_RST);
        run_frames(FRAMES_PER_PHASE, 0, 0);
    endtask

    task automatic test_sender_gaps();
        random_config(1'b0);
        run_frames(FRAMES_PER_PHASE, 51, 0);
    endtask

    task automatic test_receiver_stalls();
        random_config(1'b0);
        run_frames(FRAMES_PER_PHASE, 0, 51);
    endtask

    task automatic test_mixed_idling();
        random_config(1'b0);
        run_frames(FRAMES_PER_PHASE, 23, 23);
    endtask

    task automatic test_inverted_thresholds();
        random_config(1'b1);
        run_frames(FRAMES_PER_PHASE / 2, 23, 23);
        random_config(1'b1);
        run_frames(FRAMES_PER_PHASE / 2, 0, 0);
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest predicted one.
    always @(posedge i_clk) begin : check_results
        t_range_result got;
        t_range_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.acc_scaled = {o_accel_z_scaled, o_accel_y_scaled, o_accel_x_scaled};
            got.acc_wr     = o_accel_range_write;
            got.acc_code   = o_accel_range_code;
            got.gyr_scaled = {o_gyro_z_scaled, o_gyro_y_scaled, o_gyro_x_scaled};
            got.gyr_wr     = o_gyro_range_write;
            got.gyr_code   = o_gyro_range_code;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got.acc_scaled[i] !== want.acc_scaled[i]) begin
                        report_mismatch($sformatf("result %0d accel_%s_scaled: got %0d want %0d",
                            result_count, axis_name[i], $signed(got.acc_scaled[i]),
                            $signed(want.acc_scaled[i])));
                    end
                    if (got.gyr_scaled[i] !== want.gyr_scaled[i]) begin
                        report_mismatch($sformatf("result %0d gyro_%s_scaled: got %0d want %0d",
                            result_count, axis_name[i], $signed(got.gyr_scaled[i]),
                            $signed(want.gyr_scaled[i])));
                    end
                end
                if (got.acc_wr !== want.acc_wr || got.acc_code !== want.acc_code) begin
                    report_mismatch($sformatf("result %0d accel range: got %b/%0d want %b/%0d",
                        result_count, got.acc_wr, got.acc_code, want.acc_wr, want.acc_code));
                end
                if (got.gyr_wr !== want.gyr_wr || got.gyr_code !== want.gyr_code) begin
                    report_mismatch($sformatf("result %0d gyro range: got %b/%0d want %b/%0d",
                        result_count, got.gyr_wr, got.gyr_code, want.gyr_wr, want.gyr_code));
                end
            end
            result_count++;
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_stepping();
        test_register_extremes();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_inverted_thresholds();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
